// ===== design/thmc_pkg.sv =====
package thmc_pkg;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_ADJUST  = 2'd1,
    MODE_STAB    = 2'd2,
    MODE_ERR     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PIN  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MIN_TEMP     = 3'd0,
    CFG_MAX_TEMP     = 3'd1,
    CFG_TEMP_STEP    = 3'd2,
    CFG_TEMP_DIFF    = 3'd3,
    CFG_SET_TIMEOUT  = 3'd4,
    CFG_HOLD_LIMIT   = 3'd5,
    CFG_BOTTOM_EN    = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [1:0] INIT_OK             = 2'd0;
  localparam logic [1:0] INIT_BOTTOM_MISSING = 2'd3;

  localparam logic [2:0] FAULT_NONE        = 3'd0;
  localparam logic [2:0] FAULT_TOP_READ    = 3'd4;
  localparam logic [2:0] FAULT_BOTTOM_READ = 3'd5;

  localparam logic [7:0]  MIN_TEMP_RST    = 8'd40;
  localparam logic [7:0]  MAX_TEMP_RST    = 8'd110;
  localparam logic [3:0]  TEMP_STEP_RST   = 4'd1;
  localparam logic [6:0]  TEMP_DIFF_RST   = 7'd10;
  localparam logic [15:0] SET_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] HOLD_LIMIT_RST  = 16'd300;

endpackage

// ===== design/thmc_if.sv =====
interface thmc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              button_down;
  logic              enc_a_low;
  logic              enc_b_high;
  logic [1:0]        init_status;
  logic signed [7:0] top_reading;
  logic              top_ok;
  logic signed [7:0] bottom_reading;
  logic              bottom_ok;

  modport source (
    output valid, kind, button_down, enc_a_low, enc_b_high, init_status,
           top_reading, top_ok, bottom_reading, bottom_ok,
    input  ready
  );
  modport sink (
    input  valid, kind, button_down, enc_a_low, enc_b_high, init_status,
           top_reading, top_ok, bottom_reading, bottom_ok,
    output ready
  );
endinterface

interface thmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode_now;
  logic       heater_on;
  logic       blower_on;
  logic [7:0] target_now;
  logic [7:0] shown_temp;
  logic       heat_dot;
  logic [2:0] fault_code;

  modport source (
    output valid, mode_now, heater_on, blower_on, target_now, shown_temp,
           heat_dot, fault_code,
    input  ready
  );
  modport sink (
    input  valid, mode_now, heater_on, blower_on, target_now, shown_temp,
           heat_dot, fault_code,
    output ready
  );
endinterface

// ===== design/thermostat_mode_controller_top.sv =====
// Output: an event's result is registered on its input transfer and appears in the cycle after it.
// Throughput: one event per cycle; the single output register is refilled in
// the cycle it is taken, so input ready drops only while a result waits.
// Reset: asynchronous, active low; mode standby, counters, target, stored target,
// shown temperature, fault, heater and blower cleared, registers to defaults.
module thermostat_mode_controller_top
  import thmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  thmc_in_if.sink             in_ch,
  thmc_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [7:0]  min_temp_q, max_temp_q;
  logic [3:0]  temp_step_q;
  logic [6:0]  temp_diff_q;
  logic [15:0] set_timeout_q, hold_limit_q;
  logic        bottom_en_q;

  // controller state
  mode_e       mode_q, mode_d;
  logic [15:0] idle_q, idle_d, hold_q, hold_d;
  logic [7:0]  target_q, target_d, stored_q, stored_d, top_q, top_d;
  logic [2:0]  fault_q, fault_d;
  logic        heater_q, heater_d, blower_q, blower_d;

  // result register
  logic        out_valid_q;
  logic [1:0]  res_mode_q, res_mode_d;
  logic        res_heater_q, res_heater_d, res_blower_q, res_blower_d;
  logic [7:0]  res_target_q, res_target_d, res_temp_q, res_temp_d;
  logic [2:0]  res_fault_q, res_fault_d;

  logic        in_xfer;
  logic [15:0] idle_inc, hold_inc;
  logic [1:0]  init_eff;
  logic [9:0]  diff;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_temp_q    <= MIN_TEMP_RST;
      max_temp_q    <= MAX_TEMP_RST;
      temp_step_q   <= TEMP_STEP_RST;
      temp_diff_q   <= TEMP_DIFF_RST;
      set_timeout_q <= SET_TIMEOUT_RST;
      hold_limit_q  <= HOLD_LIMIT_RST;
      bottom_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_TEMP:    min_temp_q    <= cfg_data_i[7:0];
        CFG_MAX_TEMP:    max_temp_q    <= cfg_data_i[7:0];
        CFG_TEMP_STEP:   temp_step_q   <= cfg_data_i[3:0];
        CFG_TEMP_DIFF:   temp_diff_q   <= cfg_data_i[6:0];
        CFG_SET_TIMEOUT: set_timeout_q <= cfg_data_i;
        CFG_HOLD_LIMIT:  hold_limit_q  <= cfg_data_i;
        CFG_BOTTOM_EN:   bottom_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign idle_inc = idle_q + 16'd1;
  assign hold_inc = hold_q + 16'd1;
  assign init_eff = (in_ch.init_status == INIT_BOTTOM_MISSING && !bottom_en_q) ?
                    INIT_OK : in_ch.init_status;
  // top byte as unsigned minus bottom reading as signed
  assign diff = {2'b00, in_ch.top_reading} - {{2{in_ch.bottom_reading[7]}},
                in_ch.bottom_reading};

  // next state
  always_comb begin
    mode_d   = mode_q;
    idle_d   = idle_q;
    hold_d   = hold_q;
    target_d = target_q;
    stored_d = stored_q;
    top_d    = top_q;
    fault_d  = fault_q;
    heater_d = heater_q;
    blower_d = blower_q;
    unique case (kind_e'(in_ch.kind))
      KIND_TICK: begin
        if (mode_q != MODE_STANDBY) begin
          if (mode_q == MODE_ADJUST) begin
            idle_d = idle_inc;
            if (idle_inc > set_timeout_q) begin
              stored_d = target_q;
              mode_d   = MODE_STAB;
            end
          end
          if (in_ch.button_down) begin
            hold_d = hold_inc;
            if (hold_inc > hold_limit_q) begin
              heater_d = 1'b0;
              blower_d = 1'b0;
              stored_d = target_q;
              mode_d   = MODE_STANDBY;
            end
          end
        end
      end
      KIND_PIN: begin
        if (in_ch.enc_a_low && mode_q != MODE_STANDBY) begin
          if (in_ch.enc_b_high) begin
            if (target_q > min_temp_q) target_d = target_q - {4'd0, temp_step_q};
          end else begin
            if (target_q < max_temp_q) target_d = target_q + {4'd0, temp_step_q};
          end
          mode_d = MODE_ADJUST;
          idle_d = '0;
        end
        if (in_ch.button_down) begin
          if (mode_d == MODE_STANDBY) begin
            if (init_eff != INIT_OK) begin
              heater_d = 1'b0;
              blower_d = 1'b0;
              fault_d  = {1'b0, init_eff};
              mode_d   = MODE_ERR;
            end else begin
              // restore, falling back to the minimum when out of range
              if (stored_q < min_temp_q || stored_q > max_temp_q) begin
                target_d = min_temp_q;
              end else begin
                target_d = stored_q;
              end
              mode_d = MODE_ADJUST;
              idle_d = '0;
            end
          end
        end else begin
          hold_d = '0;
        end
      end
      KIND_READ: begin
        if (mode_q == MODE_STAB) begin
          if (!in_ch.top_ok) begin
            heater_d = 1'b0;
            blower_d = 1'b0;
            fault_d  = FAULT_TOP_READ;
            mode_d   = MODE_ERR;
          end else begin
            top_d    = in_ch.top_reading;
            heater_d = in_ch.top_reading < target_q;
            if (bottom_en_q) begin
              if (!in_ch.bottom_ok) begin
                heater_d = 1'b0;
                blower_d = 1'b0;
                fault_d  = FAULT_BOTTOM_READ;
                mode_d   = MODE_ERR;
              end else begin
                blower_d = $signed(diff) > $signed({3'b000, temp_diff_q});
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result fields from the state after the event
  always_comb begin
    res_mode_d   = mode_d;
    res_heater_d = heater_d;
    res_blower_d = blower_d;
    res_target_d = target_d;
    res_temp_d   = top_d;
    res_fault_d  = (mode_d == MODE_ERR) ? fault_d : FAULT_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STANDBY;
      idle_q      <= '0;
      hold_q      <= '0;
      target_q    <= '0;
      stored_q    <= '0;
      top_q       <= '0;
      fault_q     <= FAULT_NONE;
      heater_q    <= 1'b0;
      blower_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_q   <= mode_d;
        idle_q   <= idle_d;
        hold_q   <= hold_d;
        target_q <= target_d;
        stored_q <= stored_d;
        top_q    <= top_d;
        fault_q  <= fault_d;
        heater_q <= heater_d;
        blower_q <= blower_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_mode_q   <= res_mode_d;
      res_heater_q <= res_heater_d;
      res_blower_q <= res_blower_d;
      res_target_q <= res_target_d;
      res_temp_q   <= res_temp_d;
      res_fault_q  <= res_fault_d;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.mode_now   = res_mode_q;
  assign out_ch.heater_on  = res_heater_q;
  assign out_ch.blower_on  = res_blower_q;
  assign out_ch.target_now = res_target_q;
  assign out_ch.shown_temp = res_temp_q;
  assign out_ch.heat_dot   = res_heater_q;
  assign out_ch.fault_code = res_fault_q;

  // drives are off whenever the block sits in error
  a_err_drives_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ERR |-> !heater_q && !blower_q)
    else $error("heater or blower on in error mode");

  // a transfer always leaves a result waiting
  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted event produced no result");

  // fault code reaches the output only in error mode
  a_fault_only_in_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_fault_q != FAULT_NONE |-> res_mode_q == MODE_ERR)
    else $error("fault code shown outside error mode");

  // the held result does not change while it waits
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |=> $stable(res_target_q) && $stable(res_mode_q))
    else $error("waiting result changed");

endmodule
